[rtl/core/sdiv_pkg.sv]
// Shared types and constants for the 64-bit signed/unsigned divider.
package sdiv_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned Steps = 64;

  typedef struct packed {
    logic             mode;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } sdiv_in_t;

  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } sdiv_out_t;

  typedef struct packed {
    logic             negq;
    logic             negr;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] div;
  } sdiv_stage_t;

endpackage

[rtl/core/sdiv_prep.sv]
// Input stage: operand magnitudes and sign flags for the divide pipeline.
module sdiv_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  sdiv_pkg::sdiv_in_t  in_data,
  output logic                out_valid,
  output sdiv_pkg::sdiv_stage_t out_data
);

  logic                  a_neg;
  logic                  b_neg;
  sdiv_pkg::sdiv_stage_t stage_next;

  always_comb begin
    a_neg = in_data.mode & in_data.dividend[sdiv_pkg::DataW-1];
    b_neg = in_data.mode & in_data.divisor[sdiv_pkg::DataW-1];
    stage_next.negq = a_neg ^ b_neg;
    stage_next.negr = a_neg;
    stage_next.rem  = '0;
    stage_next.acc  = a_neg ? (~in_data.dividend + 1'b1) : in_data.dividend;
    stage_next.div  = b_neg ? (~in_data.divisor + 1'b1) : in_data.divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= stage_next;
    end
  end

endmodule

[rtl/core/sdiv_step.sv]
// One restoring shift-subtract step: resolves one quotient bit per stage.
module sdiv_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  sdiv_pkg::sdiv_stage_t in_data,
  output logic                  out_valid,
  output sdiv_pkg::sdiv_stage_t out_data
);

  logic [sdiv_pkg::DataW:0] shifted;
  logic [sdiv_pkg::DataW:0] diff;
  logic                     fits;
  sdiv_pkg::sdiv_stage_t    stage_next;

  always_comb begin
    shifted = {in_data.rem, in_data.acc[sdiv_pkg::DataW-1]};
    diff    = shifted - {1'b0, in_data.div};
    fits    = ~diff[sdiv_pkg::DataW];
    stage_next.negq = in_data.negq;
    stage_next.negr = in_data.negr;
    stage_next.div  = in_data.div;
    stage_next.rem  = fits ? diff[sdiv_pkg::DataW-1:0] : shifted[sdiv_pkg::DataW-1:0];
    stage_next.acc  = {in_data.acc[sdiv_pkg::DataW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= stage_next;
    end
  end

endmodule

[rtl/core/sdiv_post.sv]
// Output stage: sign fixup, result register and skid buffer.
module sdiv_post (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  sdiv_pkg::sdiv_stage_t in_data,
  output logic                  en,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output sdiv_pkg::sdiv_out_t   rsp_data
);

  logic                skid_valid;
  sdiv_pkg::sdiv_out_t skid_data;
  sdiv_pkg::sdiv_out_t fixed;
  logic                slot_free;

  always_comb begin
    fixed.quotient  = in_data.negq ? (~in_data.acc + 1'b1) : in_data.acc;
    fixed.remainder = in_data.negr ? (~in_data.rem + 1'b1) : in_data.rem;
    slot_free       = ~rsp_valid | ~rsp_stall;
    en              = ~skid_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      rsp_valid  <= skid_valid | in_valid;
      skid_valid <= 1'b0;
    end else if (!skid_valid && in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      rsp_data <= skid_valid ? skid_data : fixed;
    end else if (!skid_valid) begin
      skid_data <= fixed;
    end
  end

endmodule

[rtl/core/divider_64_signed_unsigned_top.sv]
// Top level of the pipelined 64-bit signed/unsigned restoring divider.
// One beat enters per cycle while req_stall is low, and each result passes
// through one operand stage, 64 shift-subtract stages (one quotient bit each)
// and one sign-fixup output stage. Mode 0 divides unsigned, mode 1 signed
// with quotient truncated toward zero and the remainder taking the dividend's
// sign. A zero divisor gives an all-ones magnitude quotient and returns the
// dividend as remainder; the signed minimum over minus one wraps. A two-entry
// output (result register plus skid) lets the pipeline keep running after
// rsp_stall rises until a result is held in the skid; req_stall is a
// registered signal.
module divider_64_signed_unsigned_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sdiv_pkg::sdiv_in_t  req_data,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sdiv_pkg::sdiv_out_t rsp_data
);

  logic                  en;
  logic                  valid_q [sdiv_pkg::Steps+1];
  sdiv_pkg::sdiv_stage_t stage_q [sdiv_pkg::Steps+1];

  assign req_stall = ~en;

  sdiv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .in_data   (req_data),
    .out_valid (valid_q[0]),
    .out_data  (stage_q[0])
  );

  for (genvar i = 0; i < sdiv_pkg::Steps; i++) begin : g_step
    sdiv_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid_q[i]),
      .in_data   (stage_q[i]),
      .out_valid (valid_q[i+1]),
      .out_data  (stage_q[i+1])
    );
  end

  sdiv_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_q[sdiv_pkg::Steps]),
    .in_data   (stage_q[sdiv_pkg::Steps]),
    .en        (en),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

[rtl/core/sdiv_checker.sv]
// Port-level checks for the divider top level, with its bind.
module sdiv_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input sdiv_pkg::sdiv_out_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response beat dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp_data))
    else $error("stalled response beat changed");

  a_stall_needs_rsp: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no response pending");

  a_stall_drains: assert property (@(posedge clk) disable iff (rst)
    req_stall && !rsp_stall |=> !req_stall)
    else $error("request stall held after response taken");

endmodule

bind divider_64_signed_unsigned_top sdiv_checker u_sdiv_checker (.*);

[verif/tb_divider_64_signed_unsigned_top.sv]
// Testbench for the pipelined 64-bit signed/unsigned divider, checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_divider_64_signed_unsigned_top;

  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned Latency     = 70;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandomItems = 1800;

  localparam logic [sdiv_pkg::DataW-1:0] AllOnes   = {sdiv_pkg::DataW{1'b1}};
  localparam logic [sdiv_pkg::DataW-1:0] SignedMin = {1'b1, {(sdiv_pkg::DataW-1){1'b0}}};
  localparam logic [sdiv_pkg::DataW-1:0] SignedMax = {1'b0, {(sdiv_pkg::DataW-1){1'b1}}};

  class division_tracker;
    sdiv_pkg::sdiv_out_t pending_results[$];
    int                  errors;

    function new();
      errors = 0;
    endfunction

    static function sdiv_pkg::sdiv_out_t divide(sdiv_pkg::sdiv_in_t req);
      logic [sdiv_pkg::DataW-1:0] num;
      logic [sdiv_pkg::DataW-1:0] den;
      logic [sdiv_pkg::DataW-1:0] quo;
      logic [sdiv_pkg::DataW-1:0] rem;
      logic                       neg_quo;
      logic                       neg_rem;
      logic                       carry;
      sdiv_pkg::sdiv_out_t        res;
      num     = req.dividend;
      den     = req.divisor;
      neg_quo = 1'b0;
      neg_rem = 1'b0;
      if (req.mode) begin
        if (num[sdiv_pkg::DataW-1]) begin
          neg_quo = 1'b1;
          neg_rem = 1'b1;
          num     = {sdiv_pkg::DataW{1'b0}} - num;
        end
        if (den[sdiv_pkg::DataW-1]) begin
          neg_quo = ~neg_quo;
          den     = {sdiv_pkg::DataW{1'b0}} - den;
        end
      end
      quo = '0;
      rem = '0;
      for (int i = 0; i < sdiv_pkg::Steps; i++) begin
        carry = rem[sdiv_pkg::DataW-1];
        rem   = {rem[sdiv_pkg::DataW-2:0], num[sdiv_pkg::DataW-1]};
        num   = num << 1;
        quo   = quo << 1;
        if (carry || rem >= den) begin
          rem    = rem - den;
          quo[0] = 1'b1;
        end
      end
      res.quotient  = neg_quo ? {sdiv_pkg::DataW{1'b0}} - quo : quo;
      res.remainder = neg_rem ? {sdiv_pkg::DataW{1'b0}} - rem : rem;
      return res;
    endfunction

    function void note_request(sdiv_pkg::sdiv_in_t req);
      pending_results.push_back(divide(req));
    endfunction

    function void check_result(sdiv_pkg::sdiv_out_t got);
      sdiv_pkg::sdiv_out_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected beat: quotient %h remainder %h", got.quotient, got.remainder);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.quotient !== want.quotient) begin
        $error("quotient: expected %h, actual %h", want.quotient, got.quotient);
        errors++;
      end
      if (got.remainder !== want.remainder) begin
        $error("remainder: expected %h, actual %h", want.remainder, got.remainder);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  sdiv_pkg::sdiv_in_t  req_data = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  sdiv_pkg::sdiv_out_t rsp_data;

  bit              gaps_on = 1'b0;
  int unsigned     quiet_cycles = 0;
  division_tracker tracker = new();

  divider_64_signed_unsigned_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always #(ClkPeriod / 2.0) clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= gaps_on && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        tracker.note_request(req_data);
      end
      if (rsp_valid && !rsp_stall) begin
        tracker.check_result(rsp_data);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input sdiv_pkg::sdiv_in_t item);
    while (gaps_on && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_division(input logic mode, input logic [sdiv_pkg::DataW-1:0] num,
                               input logic [sdiv_pkg::DataW-1:0] den);
    sdiv_pkg::sdiv_in_t item;
    item.mode     = mode;
    item.dividend = num;
    item.divisor  = den;
    send_request(item);
  endtask

  function automatic logic [sdiv_pkg::DataW-1:0] pick_operand();
    logic [sdiv_pkg::DataW-1:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: v = '0;
          1: v = {{(sdiv_pkg::DataW-1){1'b0}}, 1'b1};
          2: v = AllOnes;
          3: v = SignedMin;
          4: v = SignedMax;
          default: v = {{(sdiv_pkg::DataW-2){1'b0}}, 2'd2};
        endcase
      end
      1, 2, 3: v = v >> $urandom_range(sdiv_pkg::DataW - 1);
      4, 5:    v = {sdiv_pkg::DataW{1'b0}} - (v >> $urandom_range(sdiv_pkg::DataW - 1));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_division(1'b0, 64'd0, 64'd1);
    send_division(1'b0, AllOnes, 64'd1);
    send_division(1'b0, AllOnes, AllOnes);
    send_division(1'b0, 64'd5, 64'd0);
    send_division(1'b0, AllOnes, 64'd0);
    send_division(1'b0, 64'd100, 64'd7);
    send_division(1'b0, SignedMin, 64'd3);
    send_division(1'b0, 64'd3, AllOnes);
    send_division(1'b0, 64'd0, 64'd0);
    send_division(1'b1, -64'd7, 64'd2);
    send_division(1'b1, 64'd7, -64'd2);
    send_division(1'b1, -64'd7, -64'd2);
    send_division(1'b1, 64'd7, 64'd2);
    send_division(1'b1, SignedMin, AllOnes);
    send_division(1'b1, SignedMin, 64'd1);
    send_division(1'b1, SignedMin, SignedMin);
    send_division(1'b1, SignedMin, 64'd2);
    send_division(1'b1, SignedMin, 64'd0);
    send_division(1'b1, -64'd5, 64'd0);
    send_division(1'b1, 64'd5, 64'd0);
    send_division(1'b1, SignedMax, AllOnes);
    send_division(1'b1, AllOnes, SignedMin);
    send_division(1'b1, SignedMax, SignedMin);
    send_division(1'b1, 64'd0, 64'd0);

    for (int i = 0; i < RandomItems; i++) begin
      gaps_on = !(i >= RandomItems / 3 && i < RandomItems * 2 / 3);
      send_division(1'($urandom_range(1)), pick_operand(), pick_operand());
    end
    gaps_on = 1'b1;
    req_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sdiv_pkg.sv
rtl/core/sdiv_prep.sv
rtl/core/sdiv_step.sv
rtl/core/sdiv_post.sv
rtl/core/divider_64_signed_unsigned_top.sv
rtl/core/sdiv_checker.sv
verif/tb_divider_64_signed_unsigned_top.sv
